/* sv/bal_pkg.sv */
// Shared types and command codes for the bounded array list engine.
`timescale 1ns / 1ps
`default_nettype none
package bal_pkg;

  localparam logic [3:0] CMD_READ  = 4'd0;
  localparam logic [3:0] CMD_SRCH  = 4'd1;
  localparam logic [3:0] CMD_INS   = 4'd2;
  localparam logic [3:0] CMD_FRONT = 4'd3;
  localparam logic [3:0] CMD_BACK  = 4'd4;
  localparam logic [3:0] CMD_REM   = 4'd5;
  localparam logic [3:0] CMD_REMF  = 4'd6;
  localparam logic [3:0] CMD_REMB  = 4'd7;
  localparam logic [3:0] CMD_REPL  = 4'd8;
  localparam logic [3:0] CMD_AINS  = 4'd9;
  localparam logic [3:0] CMD_DINS  = 4'd10;
  localparam logic [3:0] CMD_SRTA  = 4'd11;
  localparam logic [3:0] CMD_SRTD  = 4'd12;

  localparam logic [0:0] REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] value;
    logic [6:0]         position;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] read_value;
    logic [6:0]         found_position;
    logic [6:0]         count;
    logic               is_empty;
    logic               is_full;
    logic               ascending;
    logic               descending;
  } rsp_t;

endpackage
`default_nettype wire

/* sv/bal_stream_if.sv */
// Valid/ready channel carrying one transaction payload.
`timescale 1ns / 1ps
`default_nettype none
interface bal_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/bal_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* sv/bal_cfg.sv */
// APB-style configuration register holding the capacity in use.
`timescale 1ns / 1ps
`default_nettype none
module bal_cfg
  import bal_pkg::*;
#(
  parameter int LIST_DEPTH = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [2:0]                      paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  output logic      [$clog2(LIST_DEPTH+1)-1:0] cap_eff
);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int PW = (CW > 7) ? CW : 7;

  logic [6:0]    capacity;
  logic [PW-1:0] capx;

  assign pready = 1'b1;
  assign capx   = PW'(capacity);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 7'd64;
    end else if (psel && penable && pwrite && paddr == {REG_CAPACITY, 2'b00}) begin
      capacity <= pwdata[6:0];
    end
  end

  always_comb begin
    if (capx == '0) begin
      cap_eff = CW'(1);
    end else if (capx > PW'(LIST_DEPTH)) begin
      cap_eff = CW'(LIST_DEPTH);
    end else begin
      cap_eff = capx[CW-1:0];
    end
  end

  assign prdata = (paddr == {REG_CAPACITY, 2'b00}) ? {25'd0, capacity} : 32'd0;
endmodule
`default_nettype wire

/* sv/bounded_array_list_engine.sv */
// Top level: command sequencer over the list memory.
// Usage:
//   req carries one command transaction (command, value, position); rsp returns
//   exactly one result transaction per command with the list status after it.
//   One command is worked at a time; req.ready is high while the sequencer waits
//   for a command, also while a finished result still waits on rsp.
//   All steps are bound by the single read port of the list memory, whose
//   read data is registered. A read takes one memory read; a search scans
//   the entries in order; inserts and removals shift the entries, then scan
//   the list for order; replace only does the order scan; sorted inserts
//   first search the position; sorts run an insertion sort, then the scan.
//   Failed commands go straight to the final step.
//   Reset (rst, synchronous) empties the list, sets capacity_in_use to 64 and
//   drops any pending result; memory contents stay undefined and are never read
//   beyond the count.
//   When rsp stalls the result is held and the sequencer waits in its final
//   step; the next command is still taken once the previous one is finished.
//   Configuration: write capacity_in_use at byte address 0 over the APB port
//   while no command is in flight.
`timescale 1ns / 1ps
`default_nettype none
module bounded_array_list_engine
  import bal_pkg::*;
#(
  parameter int LIST_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  bal_stream_if.sink       req,
  bal_stream_if.source     rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = $clog2(LIST_DEPTH);
  localparam int PW = (CW > 7) ? CW : 7;

  typedef enum logic [17:0] {
    S_IDLE = 18'h00001, S_RDW  = 18'h00002, S_SRD  = 18'h00004,
    S_SCHK = 18'h00008, S_IRD  = 18'h00010, S_IWR  = 18'h00020,
    S_RRD  = 18'h00040, S_RWR  = 18'h00080, S_FRD  = 18'h00100,
    S_FCHK = 18'h00200, S_TRI  = 18'h00400, S_TW   = 18'h00800,
    S_TRJ  = 18'h01000, S_TCHK = 18'h02000, S_CST  = 18'h04000,
    S_CRD  = 18'h08000, S_CCHK = 18'h10000, S_DONE = 18'h20000
  } state_t;

  state_t             state;
  logic [CW-1:0]      cnt, idx, jdx, ins_pos, cap_eff;
  logic signed [31:0] val, wreg, prev, rv;
  logic [CW-1:0]      fp;
  logic               ok, asc, desc, cmd_desc, rsp_valid;
  rsp_t               rsp_data;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic signed [31:0] wdata, rdata;

  logic [PW-1:0]      cntx, capx, posx, ins_p, rem_p;
  logic [CW-1:0]      ip1, im1, jm1;
  logic               ooo;

  bal_cfg #(.LIST_DEPTH(LIST_DEPTH)) u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cap_eff
  );

  bal_ram #(.WIDTH(32), .DEPTH(LIST_DEPTH)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign cntx = PW'(cnt);
  assign capx = PW'(cap_eff);
  assign posx = PW'(req.data.position);
  assign ip1  = idx + 1'b1;
  assign im1  = idx - 1'b1;
  assign jm1  = jdx - 1'b1;
  assign ooo  = cmd_desc ? (rdata < (state == S_FCHK ? val : wreg))
                         : (rdata > (state == S_FCHK ? val : wreg));

  always_comb begin
    case (req.data.command)
      CMD_INS: ins_p = posx;
      CMD_FRONT: ins_p = '0;
      default: ins_p = cntx;
    endcase
    case (req.data.command)
      CMD_REM: rem_p = posx;
      CMD_REMF: rem_p = '0;
      default: rem_p = cntx - 1'b1;
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  always_comb begin
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = rdata;
    raddr = idx[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (req.data.command == CMD_READ) begin
          raddr = posx[AW-1:0];
        end
        if (req.valid && req.data.command == CMD_REPL && posx < cntx) begin
          we    = 1'b1;
          waddr = posx[AW-1:0];
          wdata = req.data.value;
        end
      end
      S_IRD: begin
        if (idx == ins_pos) begin
          we    = 1'b1;
          waddr = ins_pos[AW-1:0];
          wdata = val;
        end else begin
          raddr = im1[AW-1:0];
        end
      end
      S_IWR, S_RWR: we = 1'b1;
      S_RRD: raddr = ip1[AW-1:0];
      S_TRJ: begin
        if (jdx == '0) begin
          we    = 1'b1;
          waddr = jdx[AW-1:0];
          wdata = wreg;
        end else begin
          raddr = jm1[AW-1:0];
        end
      end
      S_TCHK: begin
        we    = 1'b1;
        waddr = jdx[AW-1:0];
        wdata = ooo ? rdata : wreg;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      asc       <= 1'b1;
      desc      <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            ok       <= 1'b0;
            rv       <= '0;
            fp       <= '0;
            val      <= req.data.value;
            cmd_desc <= (req.data.command == CMD_DINS) || (req.data.command == CMD_SRTD);
            state    <= S_DONE;
            case (req.data.command) inside
              CMD_READ: if (posx < cntx) state <= S_RDW;
              CMD_SRCH: begin
                fp  <= cnt;
                idx <= '0;
                if (cnt != '0) state <= S_SRD;
              end
              CMD_INS, CMD_FRONT, CMD_BACK: begin
                if (!(cntx >= capx || ins_p > cntx)) begin
                  ins_pos <= ins_p[CW-1:0];
                  idx     <= cnt;
                  state   <= S_IRD;
                end
              end
              CMD_REM, CMD_REMF, CMD_REMB: begin
                if (cnt != '0 && rem_p < cntx) begin
                  idx   <= rem_p[CW-1:0];
                  state <= S_RRD;
                end
              end
              CMD_REPL: begin
                if (posx < cntx) begin
                  ok    <= 1'b1;
                  state <= S_CST;
                end
              end
              CMD_AINS, CMD_DINS: begin
                if ((req.data.command == CMD_AINS ? asc : desc) && cntx < capx) begin
                  idx   <= '0;
                  state <= S_FRD;
                end
              end
              CMD_SRTA, CMD_SRTD: begin
                ok  <= 1'b1;
                idx <= CW'(1);
                if (cntx >= PW'(2)) state <= S_TRI;
              end
              default: ;
            endcase
          end
        end
        S_RDW: begin
          rv    <= rdata;
          ok    <= 1'b1;
          state <= S_DONE;
        end
        S_SRD: state <= S_SCHK;
        S_SCHK: begin
          if (rdata == val) begin
            fp    <= idx;
            ok    <= 1'b1;
            state <= S_DONE;
          end else if (ip1 == cnt) begin
            state <= S_DONE;
          end else begin
            idx   <= ip1;
            state <= S_SRD;
          end
        end
        S_IRD: begin
          if (idx == ins_pos) begin
            cnt   <= cnt + 1'b1;
            ok    <= 1'b1;
            state <= S_CST;
          end else begin
            state <= S_IWR;
          end
        end
        S_IWR: begin
          idx   <= im1;
          state <= S_IRD;
        end
        S_RRD: begin
          if (ip1 >= cnt) begin
            cnt   <= cnt - 1'b1;
            ok    <= 1'b1;
            state <= S_CST;
          end else begin
            state <= S_RWR;
          end
        end
        S_RWR: begin
          idx   <= ip1;
          state <= S_RRD;
        end
        S_FRD: begin
          if (idx == cnt) begin
            ins_pos <= idx;
            state   <= S_IRD;
          end else begin
            state <= S_FCHK;
          end
        end
        S_FCHK: begin
          if (ooo) begin
            ins_pos <= idx;
            idx     <= cnt;
            state   <= S_IRD;
          end else begin
            idx   <= ip1;
            state <= S_FRD;
          end
        end
        S_TRI: begin
          if (idx == cnt) begin
            state <= S_CST;
          end else begin
            jdx   <= idx;
            state <= S_TW;
          end
        end
        S_TW: begin
          wreg  <= rdata;
          state <= S_TRJ;
        end
        S_TRJ: begin
          if (jdx == '0) begin
            idx   <= ip1;
            state <= S_TRI;
          end else begin
            state <= S_TCHK;
          end
        end
        S_TCHK: begin
          if (ooo) begin
            jdx   <= jm1;
            state <= S_TRJ;
          end else begin
            idx   <= ip1;
            state <= S_TRI;
          end
        end
        S_CST: begin
          idx   <= '0;
          asc   <= 1'b1;
          desc  <= 1'b1;
          state <= (cntx >= PW'(2)) ? S_CRD : S_DONE;
        end
        S_CRD: state <= S_CCHK;
        S_CCHK: begin
          if (idx != '0) begin
            if (prev > rdata) asc <= 1'b0;
            if (prev < rdata) desc <= 1'b0;
          end
          prev <= rdata;
          if (ip1 == cnt) begin
            state <= S_DONE;
          end else begin
            idx   <= ip1;
            state <= S_CRD;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_data.ok              <= ok;
            rsp_data.read_value      <= rv;
            rsp_data.found_position  <= 7'(PW'(fp));
            rsp_data.count           <= cntx[6:0];
            rsp_data.is_empty        <= (cnt == '0);
            rsp_data.is_full         <= (cntx >= capx);
            rsp_data.ascending       <= asc;
            rsp_data.descending      <= desc;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cntx <= PW'(LIST_DEPTH))
    else $error("entry count above list depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != S_IDLE)
    else $error("accepted transaction not worked");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |=> cnt == $past(cnt) || cnt == $past(cnt) + 1'b1
                        || cnt + 1'b1 == $past(cnt))
    else $error("entry count jumped");

endmodule
`default_nettype wire

/* bench/bal_list_checker.sv */
// Checker: watches both channels, predicts list results and compares them.
`timescale 1ns / 1ps
`default_nettype none
module bal_list_checker
  import bal_pkg::*;
#(
  parameter int LIST_DEPTH = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  input  wire logic req_ready,
  input  wire req_t req_data,
  input  wire logic rsp_valid,
  input  wire logic rsp_ready,
  input  wire rsp_t rsp_data,
  input  wire logic cap_we,
  input  wire logic [6:0] cap_wdata,
  output int        mismatches,
  output int        pending
);

  logic signed [31:0] words [LIST_DEPTH];
  int                 n_words;
  int                 cap_reg;
  rsp_t               expected_rsps [$];

  assign pending = expected_rsps.size();

  function automatic int eff_cap();
    if (cap_reg < 1) return 1;
    if (cap_reg > LIST_DEPTH) return LIST_DEPTH;
    return cap_reg;
  endfunction

  function automatic bit is_asc();
    for (int i = 1; i < n_words; i++) if (words[i-1] > words[i]) return 0;
    return 1;
  endfunction

  function automatic bit is_desc();
    for (int i = 1; i < n_words; i++) if (words[i-1] < words[i]) return 0;
    return 1;
  endfunction

  function automatic bit put_word(int p, logic signed [31:0] w);
    if (n_words >= eff_cap() || p > n_words) return 0;
    for (int i = n_words; i > p; i--) words[i] = words[i-1];
    words[p] = w;
    n_words++;
    return 1;
  endfunction

  function automatic bit take_word(int p);
    if (p >= n_words) return 0;
    for (int i = p; i + 1 < n_words; i++) words[i] = words[i+1];
    n_words--;
    return 1;
  endfunction

  function automatic void sort_words(bit down);
    logic signed [31:0] w;
    int j;
    for (int i = 1; i < n_words; i++) begin
      w = words[i];
      j = i;
      while (j > 0 && (down ? words[j-1] < w : words[j-1] > w)) begin
        words[j] = words[j-1];
        j--;
      end
      words[j] = w;
    end
  endfunction

  function automatic rsp_t apply_command(req_t r);
    rsp_t o;
    int   p, i;
    o = '0;
    p = r.position;
    case (r.command)
      CMD_READ: if (p < n_words) begin
        o.ok = 1;
        o.read_value = words[p];
      end
      CMD_SRCH: begin
        o.found_position = 7'(n_words);
        for (i = 0; i < n_words; i++) if (words[i] == r.value) begin
          o.found_position = 7'(i);
          o.ok = 1;
          break;
        end
      end
      CMD_INS:   o.ok = put_word(p, r.value);
      CMD_FRONT: o.ok = put_word(0, r.value);
      CMD_BACK:  o.ok = put_word(n_words, r.value);
      CMD_REM:   o.ok = take_word(p);
      CMD_REMF:  o.ok = take_word(0);
      CMD_REMB:  o.ok = n_words > 0 ? take_word(n_words - 1) : 1'b0;
      CMD_REPL: if (p < n_words) begin
        words[p] = r.value;
        o.ok = 1;
      end
      CMD_AINS: if (is_asc()) begin
        for (i = 0; i < n_words; i++) if (words[i] > r.value) break;
        o.ok = put_word(i, r.value);
      end
      CMD_DINS: if (is_desc()) begin
        for (i = 0; i < n_words; i++) if (words[i] < r.value) break;
        o.ok = put_word(i, r.value);
      end
      CMD_SRTA: begin
        sort_words(0);
        o.ok = 1;
      end
      CMD_SRTD: begin
        sort_words(1);
        o.ok = 1;
      end
      default: ;
    endcase
    o.count = 7'(n_words);
    o.is_empty = n_words == 0;
    o.is_full = n_words >= eff_cap();
    o.ascending = is_asc();
    o.descending = is_desc();
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      n_words <= 0;
      cap_reg <= 64;
      expected_rsps.delete();
      mismatches <= 0;
    end else begin
      if (cap_we) cap_reg = cap_wdata;
      if (req_valid && req_ready) expected_rsps.push_back(apply_command(req_data));
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %p", rsp_data);
          mismatches <= mismatches + 1;
        end else begin
          e = expected_rsps.pop_front();
          if (e !== rsp_data) begin
            if (mismatches < 10) $display("mismatch exp %p act %p", e, rsp_data);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

/* bench/tb_bounded_array_list_engine.sv */
// Testbench top: drives commands and capacity writes, gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_bounded_array_list_engine;
  import bal_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches, pending, quiet_cycles;
  bit          sender_quiet, hold_off, long_hold;
  int          list_size_est;

  bal_stream_if #(.T(req_t)) req_ch ();
  bal_stream_if #(.T(rsp_t)) rsp_ch ();

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    req_ch.valid = 0;
    req_ch.data = '0;
    rsp_ch.ready = 0;
  end

  bounded_array_list_engine dut (
    .clk, .rst, .req(req_ch.sink), .rsp(rsp_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  bal_list_checker chk (
    .clk, .rst,
    .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_data(req_ch.data),
    .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_ch.data),
    .cap_we(psel && penable && pwrite && pready && paddr == {REG_CAPACITY, 2'b00}),
    .cap_wdata(pwdata[6:0]), .mismatches, .pending
  );

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  always begin
    int gap;
    @(posedge clk);
    if (long_hold) begin
      rsp_ch.ready <= 0;
      repeat (400) @(posedge clk);
      long_hold = 0;
    end else if (!hold_off && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 17);
      rsp_ch.ready <= 0;
      repeat (gap) @(posedge clk);
    end
    rsp_ch.ready <= 1;
  end

  task automatic write_capacity(int cap_val);
    repeat (300) @(posedge clk);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {REG_CAPACITY, 2'b00};
    pwdata <= 32'(cap_val);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic send_command(logic [3:0] op, logic signed [31:0] w, logic [6:0] p);
    req_t r;
    int gap;
    if (!sender_quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      req_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    r.command = op;
    r.value = w;
    r.position = p;
    req_ch.valid <= 1;
    req_ch.data <= r;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic drain();
    req_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'($urandom_range(0, 6)) - 3;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_phase(int items, int max_pos);
    logic [3:0] op;
    for (int k = 0; k < items; k++) begin
      op = $urandom_range(0, 99) < 3 ? 4'($urandom_range(13, 15))
                                     : 4'($urandom_range(0, 12));
      send_command(op, rand_word(), 7'($urandom_range(0, max_pos)));
    end
  endtask

  initial begin
    sender_quiet = 0;
    hold_off = 0;
    long_hold = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_command(CMD_REMF, 0, 0);
    send_command(CMD_REMB, 0, 0);
    send_command(CMD_REM, 0, 0);
    send_command(CMD_READ, 0, 0);
    send_command(CMD_SRTA, 0, 0);
    send_command(CMD_SRCH, 5, 0);
    send_command(CMD_AINS, 32'sh8000_0000, 0);
    send_command(CMD_AINS, 32'sh7fff_ffff, 0);
    send_command(CMD_AINS, 0, 0);
    send_command(CMD_INS, -1, 2);
    send_command(CMD_INS, 9, 9);
    send_command(CMD_FRONT, 4, 0);
    send_command(CMD_BACK, -4, 0);
    send_command(CMD_AINS, 1, 0);
    send_command(CMD_DINS, 1, 0);
    send_command(CMD_SRTD, 0, 0);
    send_command(CMD_DINS, 2, 0);
    send_command(CMD_SRCH, 0, 0);
    send_command(CMD_READ, 0, 64);
    send_command(CMD_REPL, 32'sh7fff_ffff, 1);
    send_command(CMD_REPL, 3, 127);
    send_command(CMD_REM, 0, 1);
    send_command(4'd15, 0, 0);
    send_command(CMD_REMB, 0, 0);
    drain();
    write_capacity(0);
    random_phase(60, 3);
    drain();
    write_capacity(4);
    random_phase(100, 6);
    drain();
    write_capacity(127);
    long_hold = 1;
    random_phase(150, 127);
    drain();
    sender_quiet = 1;
    repeat (50) @(posedge clk);
    sender_quiet = 0;
    write_capacity(64);
    for (int k = 0; k < 66; k++) send_command(CMD_BACK, rand_word(), 0);
    random_phase(150, 70);
    drain();
    write_capacity(2);
    random_phase(100, 4);
    drain();
    write_capacity(20);
    random_phase(120, 24);
    sender_quiet = 1;
    hold_off = 1;
    random_phase(60, 24);
    drain();
    repeat (500) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
